FILE: src/fnl_pkg.sv
package fnl_pkg;

    localparam int MAX_PARTICLES = 64;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic RESULT_SUMMARY = 1'b0;
    localparam logic RESULT_ENTRY   = 1'b1;

    localparam logic CFG_PARTICLE_COUNT = 1'b0;
    localparam logic CFG_SEARCH_RADIUS  = 1'b1;

    localparam logic [6:0]  COUNT_RESET  = 7'd1;
    localparam logic [15:0] RADIUS_RESET = 16'd256;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         particle_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [5:0]  neighbor_index;
        logic [11:0] list_start;
        logic [6:0]  list_count;
        logic [12:0] total_neighbors;
        logic        last;
    } t_out_item;

endpackage

FILE: src/fixed_radius_neighbor_lists_top.sv
// Fixed-radius neighbor lists over a set of 2D particle positions.
// The input channel takes load, build and query requests. A load stores one
// position, if its index is below the n particles in use, and gives no
// result. A build tests every ordered pair of those n particles, one pair at
// a time through a shared difference, square and compare path, and writes
// each hit to the packed neighbor memory. It ends with one summary result
// that carries the total. A query reads the particle's start and count from
// the table memory and streams its neighbors from the neighbor memory, one
// entry per cycle while the receiver takes them.
// One request is worked on at a time, and new requests are held off until the
// current one has handed its last result to the output register.
// The output register lets an idle block take loads while a result waits.
// When the receiver stalls, the sequencer holds and nothing is lost.
// The configuration channel is always ready and sets the particle count and
// the search radius. Reset clears the configuration to its defaults and
// forgets any earlier build, so queries give no result until the next build.
// Position and list memories are not cleared by reset.
module fixed_radius_neighbor_lists_top import fnl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IW    = $clog2(MAX_PARTICLES);
    localparam int CW    = $clog2(MAX_PARTICLES + 1);
    localparam int DEPTH = MAX_PARTICLES * MAX_PARTICLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int TBW   = CW + AW;

    typedef enum logic [3:0] {
        S_IDLE, S_RDI, S_LDI, S_DIFF, S_SQ, S_CMP, S_ROW, S_BOUT, S_QT, S_QD
    } t_state;

    t_state r_state, n_state;
    logic r_ovalid, n_ovalid;
    logic r_built, n_built;
    logic [6:0] r_count, n_count;
    logic [15:0] r_radius, n_radius;
    logic [CW-1:0] r_bcount, n_bcount;

    logic [IW-1:0] r_i, n_i, r_j, n_j;
    logic [CW-1:0] r_c, n_c, r_bn, n_bn, r_qc, n_qc, r_k, n_k;
    logic [TW-1:0] r_p, n_p, r_total, n_total;
    logic [AW-1:0] r_rs, n_rs, r_qs, n_qs;
    logic [31:0] r_pi, n_pi, r_r2;
    logic signed [16:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [33:0] n_sx, n_sy;
    logic [33:0] r_sx, r_sy;
    t_out_item r_out, n_out;

    logic pos_we;
    logic [IW-1:0] pos_raddr;
    logic [31:0] pos_rdata;
    logic tab_we;
    logic [IW-1:0] tab_raddr;
    logic [TBW-1:0] tab_rdata;
    logic nb_we;
    logic [AW-1:0] nb_raddr;
    logic [IW-1:0] nb_rdata;

    logic in_acc, slot_free, hit, last_j, last_i, last_k;
    logic [CW-1:0] eff_n;
    logic [34:0] d2;

    fnl_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (IW'(i_in_data.particle_index)),
        .i_wdata ({i_in_data.pos_x, i_in_data.pos_y}),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    fnl_ram #(.WIDTH(TBW), .DEPTH(MAX_PARTICLES)) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (r_i),
        .i_wdata ({r_c, r_rs}),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    fnl_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_nb_ram (
        .i_clk   (i_clk),
        .i_we    (nb_we),
        .i_waddr (AW'(r_p)),
        .i_wdata (r_j),
        .i_raddr (nb_raddr),
        .o_rdata (nb_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_ovalid || i_out_ready;
    assign d2        = 35'(r_sx) + 35'(r_sy);
    assign hit       = (d2 <= 35'(r_r2));
    assign last_j    = (32'(r_j) + 1 == 32'(r_bn));
    assign last_i    = (32'(r_i) + 1 == 32'(r_bn));
    assign last_k    = (32'(r_k) + 1 == 32'(r_qc));
    assign n_dx      = $signed({r_pi[31], r_pi[31:16]}) -
                       $signed({pos_rdata[31], pos_rdata[31:16]});
    assign n_dy      = $signed({r_pi[15], r_pi[15:0]}) -
                       $signed({pos_rdata[15], pos_rdata[15:0]});
    assign n_sx      = r_dx * r_dx;
    assign n_sy      = r_dy * r_dy;

    always_comb begin
        if (r_count == 7'd0) begin
            eff_n = CW'(1);
        end else if (32'(r_count) > 32'(MAX_PARTICLES)) begin
            eff_n = CW'(MAX_PARTICLES);
        end else begin
            eff_n = CW'(r_count);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        n_built  = r_built;
        n_count  = r_count;
        n_radius = r_radius;
        n_bcount = r_bcount;
        n_i      = r_i;
        n_j      = r_j;
        n_c      = r_c;
        n_bn     = r_bn;
        n_qc     = r_qc;
        n_k      = r_k;
        n_p      = r_p;
        n_total  = r_total;
        n_rs     = r_rs;
        n_qs     = r_qs;
        n_pi     = r_pi;
        n_out    = r_out;
        pos_we    = 1'b0;
        pos_raddr = r_j;
        tab_we    = 1'b0;
        tab_raddr = IW'(i_in_data.particle_index);
        nb_we     = 1'b0;
        nb_raddr  = r_qs + AW'(r_k);

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PARTICLE_COUNT: n_count  = i_cfg_data[6:0];
                CFG_SEARCH_RADIUS:  n_radius = i_cfg_data;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.req_type)
                        REQ_LOAD: begin
                            pos_we = (32'(i_in_data.particle_index) < 32'(eff_n));
                        end
                        REQ_BUILD: begin
                            n_bn    = eff_n;
                            n_i     = '0;
                            n_j     = '0;
                            n_c     = '0;
                            n_p     = '0;
                            n_rs    = '0;
                            n_state = S_RDI;
                        end
                        REQ_QUERY: begin
                            if (r_built &&
                                32'(i_in_data.particle_index) < 32'(r_bcount)) begin
                                n_state = S_QT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDI: begin
                pos_raddr = r_i;
                n_state   = S_LDI;
            end
            S_LDI: begin
                n_pi    = pos_rdata;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_state = S_SQ;
            end
            S_SQ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    nb_we = 1'b1;
                    n_p   = r_p + 1'b1;
                    n_c   = r_c + 1'b1;
                end
                if (last_j) begin
                    n_state = S_ROW;
                end else begin
                    n_j       = r_j + 1'b1;
                    pos_raddr = r_j + 1'b1;
                    n_state   = S_DIFF;
                end
            end
            S_ROW: begin
                tab_we = 1'b1;
                n_rs   = AW'(r_p);
                n_c    = '0;
                n_j    = '0;
                if (last_i) begin
                    n_total = r_p;
                    n_state = S_BOUT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RDI;
                end
            end
            S_BOUT: begin
                if (slot_free) begin
                    n_out.result_kind     = RESULT_SUMMARY;
                    n_out.neighbor_index  = '0;
                    n_out.list_start      = '0;
                    n_out.list_count      = '0;
                    n_out.total_neighbors = 13'(r_total);
                    n_out.last            = 1'b1;
                    n_ovalid = 1'b1;
                    n_built  = 1'b1;
                    n_bcount = r_bn;
                    n_state  = S_IDLE;
                end
            end
            S_QT: begin
                n_qs     = tab_rdata[AW-1:0];
                n_qc     = tab_rdata[TBW-1:AW];
                n_k      = '0;
                nb_raddr = tab_rdata[AW-1:0];
                if (tab_rdata[TBW-1:AW] == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_QD;
                end
            end
            S_QD: begin
                if (slot_free) begin
                    n_out.result_kind     = RESULT_ENTRY;
                    n_out.neighbor_index  = 6'(nb_rdata);
                    n_out.list_start      = 12'(r_qs);
                    n_out.list_count      = 7'(r_qc);
                    n_out.total_neighbors = 13'(r_total);
                    n_out.last            = last_k;
                    n_ovalid = 1'b1;
                    if (last_k) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k      = r_k + 1'b1;
                        nb_raddr = r_qs + AW'(r_k + 1'b1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_built  <= 1'b0;
            r_count  <= COUNT_RESET;
            r_radius <= RADIUS_RESET;
            r_bcount <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_built  <= n_built;
            r_count  <= n_count;
            r_radius <= n_radius;
            r_bcount <= n_bcount;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_c     <= n_c;
        r_bn    <= n_bn;
        r_qc    <= n_qc;
        r_k     <= n_k;
        r_p     <= n_p;
        r_total <= n_total;
        r_rs    <= n_rs;
        r_qs    <= n_qs;
        r_pi    <= n_pi;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_r2    <= 32'(r_radius) * 32'(r_radius);
        r_out   <= n_out;
    end

endmodule

FILE: src/fnl_ram.sv
module fnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import fnl_pkg::*;

    localparam int MAX_P = MAX_PARTICLES;
    localparam int STORE_DEPTH = MAX_P * MAX_P;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_REQUESTS = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_PARTICLE_COUNT;
    logic [15:0] cfg_data = '0;

    fixed_radius_neighbor_lists_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mirror of the block: positions, lists and registers.
    logic signed [15:0] part_x [MAX_P];
    logic signed [15:0] part_y [MAX_P];
    int                 list_len [MAX_P];
    int                 list_base [MAX_P];
    logic [5:0]         list_entries [STORE_DEPTH];
    logic [6:0]         count_reg = COUNT_RESET;
    logic [15:0]        radius_reg = RADIUS_RESET;
    bit                 lists_ready = 1'b0;
    int                 lists_n = 0;
    int                 lists_total = 0;
    t_out_item          pending_results [$];

    int mismatches = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int builds_sent = 0;

    // Stimulus-side view of the block.
    int gen_n = 1;
    int gen_built_n = 0;
    bit loaded [MAX_P];
    int cx = 0;
    int cy = 0;
    int spread = 300;
    bit steady = 1'b0;
    int hold_asked = 0;

    function automatic int active_count(logic [6:0] c);
        if (c == 7'd0) return 1;
        if (c > 7'd64) return MAX_P;
        return int'(c);
    endfunction

    function automatic bit within_radius(int a, int b);
        longint dx, dy, r2;
        dx = longint'(part_x[a]) - longint'(part_x[b]);
        dy = longint'(part_y[a]) - longint'(part_y[b]);
        r2 = longint'(radius_reg) * longint'(radius_reg);
        return (dx * dx + dy * dy) <= r2;
    endfunction

    function automatic void apply_request(t_in_item req);
        int n, sum, c, p, idx;
        t_out_item r;
        n = active_count(count_reg);
        idx = int'(req.particle_index);
        case (req.req_type)
            REQ_LOAD: begin
                if (idx < n) begin
                    part_x[idx] = req.pos_x;
                    part_y[idx] = req.pos_y;
                end
            end
            REQ_BUILD: begin
                sum = 0;
                for (int i = 0; i < n; i++) begin
                    c = 0;
                    for (int j = 0; j < n; j++) if (within_radius(i, j)) c++;
                    list_len[i] = c;
                    list_base[i] = sum;
                    sum += c;
                end
                for (int i = 0; i < n; i++) begin
                    p = list_base[i];
                    for (int j = 0; j < n; j++) begin
                        if (within_radius(i, j) && p < STORE_DEPTH) begin
                            list_entries[p] = 6'(j);
                            p++;
                        end
                    end
                end
                lists_ready = 1'b1;
                lists_n = n;
                lists_total = sum;
                r = '0;
                r.result_kind = RESULT_SUMMARY;
                r.total_neighbors = 13'(sum);
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            REQ_QUERY: begin
                if (lists_ready && idx < lists_n) begin
                    c = (list_len[idx] > MAX_P) ? MAX_P : list_len[idx];
                    for (int k = 0; k < c; k++) begin
                        p = list_base[idx] + k;
                        r.result_kind = RESULT_ENTRY;
                        r.neighbor_index = (p < STORE_DEPTH) ? list_entries[p] : 6'd0;
                        r.list_start = 12'(list_base[idx]);
                        r.list_count = 7'(c);
                        r.total_neighbors = 13'(lists_total);
                        r.last = (k == c - 1);
                        pending_results.push_back(r);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 50) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %p arrived with nothing pending", got));
            return;
        end
        want = pending_results.pop_front();
        check_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
        check_field("neighbor_index", 16'(got.neighbor_index), 16'(want.neighbor_index));
        check_field("list_start", 16'(got.list_start), 16'(want.list_start));
        check_field("list_count", 16'(got.list_count), 16'(want.list_count));
        check_field("total_neighbors", 16'(got.total_neighbors), 16'(want.total_neighbors));
        check_field("last", 16'(got.last), 16'(want.last));
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PARTICLE_COUNT) begin
                    count_reg = cfg_data[6:0];
                end else begin
                    radius_reg = cfg_data;
                end
            end
            if (in_valid && in_ready) apply_request(in_data);
            if (out_valid && out_ready) begin
                results_checked++;
                check_result(out_data);
            end
        end
    end

    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    always @(posedge clk) begin
        int r;
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (steady) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                out_ready <= 1'b1;
            end else if (r < 94) begin
                stall_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                stall_left = $urandom_range(10, 50);
                out_ready <= 1'b0;
            end
        end
    end

    task automatic send_request(t_in_item req, bit counted);
        int gap, r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 96) gap = $urandom_range(4, 12);
        else gap = $urandom_range(25, 70);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (counted) requests_sent++;
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_count(logic [6:0] cnt);
        write_register(CFG_PARTICLE_COUNT, {9'($urandom_range(0, 511)), cnt});
        gen_n = active_count(cnt);
    endtask

    task automatic set_radius(logic [15:0] radius);
        write_register(CFG_SEARCH_RADIUS, radius);
    endtask

    function automatic logic signed [15:0] scatter_coord(int center, int span);
        return 16'(center + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic load_position(int idx, logic signed [15:0] x, logic signed [15:0] y);
        t_in_item req;
        bit takes;
        takes = idx < gen_n;
        req.req_type = REQ_LOAD;
        req.particle_index = 6'(idx);
        req.pos_x = x;
        req.pos_y = y;
        if (takes) loaded[idx] = 1'b1;
        send_request(req, takes);
    endtask

    task automatic load_scattered(int idx);
        if ($urandom_range(0, 99) < 15) begin
            load_position(idx, 16'($urandom), 16'($urandom));
        end else begin
            load_position(idx, scatter_coord(cx, spread), scatter_coord(cy, spread));
        end
    endtask

    task automatic query_particle(int idx);
        t_in_item req;
        req = '{REQ_QUERY, 6'(idx), 16'($urandom), 16'($urandom)};
        send_request(req, idx < gen_built_n);
    endtask

    task automatic build_lists();
        t_in_item req;
        for (int i = 0; i < gen_n; i++) if (!loaded[i]) load_scattered(i);
        req = '{REQ_BUILD, 6'($urandom), 16'($urandom), 16'($urandom)};
        gen_built_n = gen_n;
        builds_sent++;
        send_request(req, 1'b1);
    endtask

    task automatic send_unused();
        t_in_item req;
        req = '{REQ_UNUSED, 6'($urandom), 16'($urandom), 16'($urandom)};
        send_request(req, 1'b0);
    endtask

    task automatic test_after_reset();
        query_particle(0);
        send_unused();
        load_position(0, 16'sd0, 16'sd0);
        load_position(5, 16'sh1234, -16'sd100);
        build_lists();
        query_particle(0);
        query_particle(1);
    endtask

    task automatic test_count_zero();
        quiesce();
        set_count(7'd0);
        load_position(1, 16'sd512, 16'sd512);
        load_position(0, 16'sd100, -16'sd100);
        build_lists();
        query_particle(0);
        query_particle(1);
    endtask

    task automatic test_radius_boundary();
        quiesce();
        set_count(7'd4);
        set_radius(16'd1280);
        load_position(0, 16'sd0, 16'sd0);
        load_position(1, 16'sd768, 16'sd1024);
        load_position(2, 16'sd769, 16'sd1024);
        load_position(3, -16'sd1280, 16'sd0);
        build_lists();
        for (int i = 0; i < 4; i++) query_particle(i);
    endtask

    task automatic test_extreme_positions();
        quiesce();
        set_radius(16'hFFFF);
        load_position(0, 16'sh8000, 16'sh8000);
        load_position(1, 16'sh7FFF, 16'sh7FFF);
        load_position(2, 16'sh8000, 16'sh7FFF);
        load_position(3, 16'sh7FFF, 16'sh8000);
        build_lists();
        query_particle(0);
        query_particle(1);
        quiesce();
        set_radius(16'd0);
        build_lists();
        load_position(2, 16'sd0, 16'sd0);
        query_particle(2);
        query_particle(3);
    endtask

    task automatic test_receiver_hold();
        quiesce();
        set_count(7'd24);
        set_radius(16'd40000);
        cx = 5000;
        cy = -7000;
        spread = 2000;
        for (int i = 0; i < 24; i++) load_scattered(i);
        build_lists();
        hold_asked <= hold_asked + 1;
        steady = 1'b1;
        for (int i = 0; i < 8; i++) query_particle($urandom_range(0, 23));
        steady = 1'b0;
    endtask

    task automatic test_random_frames(int target);
        int r, k, m, goal;
        bit first;
        goal = requests_sent + target;
        first = 1'b1;
        while (requests_sent < goal) begin
            quiesce();
            r = $urandom_range(0, 99);
            if (first) set_count(7'd127);
            else if (r < 8) set_count(7'd0);
            else if (r < 16) set_count(7'd64);
            else if (r < 22) set_count(7'($urandom_range(65, 127)));
            else if (r < 30) set_count(7'($urandom_range(17, 40)));
            else set_count(7'($urandom_range(2, 12)));
            first = 1'b0;
            spread = $urandom_range(0, 1500);
            cx = int'($urandom_range(0, 40000)) - 20000;
            cy = int'($urandom_range(0, 40000)) - 20000;
            r = $urandom_range(0, 99);
            if (r < 10) set_radius(16'd0);
            else if (r < 16) set_radius(16'hFFFF);
            else if (r < 26) set_radius(16'($urandom));
            else set_radius(16'($urandom_range(0, 2 * spread + 64)));
            steady = ($urandom_range(0, 3) == 0);
            k = $urandom_range(1, (gen_n < 10) ? gen_n : 10);
            repeat (k) load_scattered($urandom_range(0, gen_n - 1));
            if (gen_n < MAX_P && $urandom_range(0, 1) == 1)
                load_scattered($urandom_range(gen_n, MAX_P - 1));
            build_lists();
            m = $urandom_range(3, 10);
            repeat (m) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    query_particle($urandom_range(0, gen_n - 1));
                end else if (r < 77) begin
                    load_scattered($urandom_range(0, gen_n - 1));
                end else if (r < 85) begin
                    query_particle($urandom_range(0, MAX_P - 1));
                end else if (r < 92) begin
                    send_unused();
                end else begin
                    load_scattered($urandom_range(0, MAX_P - 1));
                end
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_count_zero();
        test_radius_boundary();
        test_extreme_positions();
        test_receiver_hold();
        test_random_frames(RANDOM_REQUESTS);
        quiesce();
        $display("Sent %0d requests with %0d builds; checked %0d results.",
                 requests_sent, builds_sent, results_checked);
        $display("Counts from 1 to 64, radii from 0 to full scale, and a long output stall.");
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Timed out with %0d results still pending.", pending_results.size());
        $display("tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/fnl_pkg.sv
src/fnl_ram.sv
src/fixed_radius_neighbor_lists_top.sv
bench/tb.sv
